[rtl/lmts_pkg.sv]
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types and constants for the LCD mode timing sequencer.
// ----------------------------------------------------------------------------
package lmts_pkg;

  // scan lines shown before vertical blank starts
  localparam logic [7:0] VISIBLE_LINES = 8'd144;

  // dot budgets, wide enough for the vertical blank budget
  localparam int DOTS_W = 13;
  localparam logic [DOTS_W-1:0] DOTS_SEARCH = 13'd80;
  localparam logic [DOTS_W-1:0] DOTS_XFER   = 13'd172;
  localparam logic [DOTS_W-1:0] DOTS_HBLANK = 13'd204;
  localparam logic [DOTS_W-1:0] DOTS_VBLANK = 13'd4560;
  localparam logic [DOTS_W-1:0] DOTS_LINE   = 13'd456;
  localparam int VBLANK_LINES = 10;

  // sequencer state
  typedef enum logic [4:0] {
    ST_OFF    = 5'b00001,
    ST_HBLANK = 5'b00010,
    ST_VBLANK = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_XFER   = 5'b10000
  } mode_t;

  // lcd_mode codes seen on the result
  localparam logic [1:0] LCD_HBLANK = 2'd0;
  localparam logic [1:0] LCD_VBLANK = 2'd1;
  localparam logic [1:0] LCD_SEARCH = 2'd2;
  localparam logic [1:0] LCD_XFER   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_DISPLAY_ENABLE     = 2'd0;
  localparam logic [1:0] REG_LINE_COMPARE       = 2'd1;
  localparam logic [1:0] REG_STATUS_IRQ_ENABLES = 2'd2;

  // result word layout
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_MODE_LSB = 0;
  localparam int OUT_LINE_LSB = 2;
  localparam int OUT_COINC    = 10;
  localparam int OUT_VBLANK   = 11;
  localparam int OUT_STATUS   = 12;

endpackage

[rtl/lcd_mode_timing_sequencer_top.sv]
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_top
// LCD mode sequencer driven by elapsed dot counts, one result per transaction.
// ----------------------------------------------------------------------------
// usage
//   - slave stream: each transaction carries the number of dot clocks that
//     passed since the previous one (1 to 24 in normal use, any 5-bit value ok)
//   - master stream: one result per input transaction with the lcd mode, the
//     scan line, line-compare coincidence and two one-shot interrupt flags
//   - config port: cfg_write with cfg_index / cfg_data, write only while idle
// timing
//   - a transaction is sequenced in the cycle it is accepted; its result is
//     valid on the master side the next cycle
//   - throughput is one transaction per cycle unless a result stalls; the dot
//     subtract from the mode budget plus the vblank line compares set the path
// reset
//   - synchronous rst clears the config registers (display off), puts the
//     sequencer in the off state at line 0 and empties the result register
// backpressure
//   - the result register holds while m_tready is low; s_tready drops only
//     while a result is held and the receiver is not taking it
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] elapsed_dots, [7:5] zero
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] lcd_mode, [9:2] current_line,
                                 // [10] coincidence, [11] vblank_irq,
                                 // [12] status_irq, [15:13] zero
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic       display_enable;
  logic [7:0] line_compare;
  logic [3:0] status_irq_enables;

  // sequencer state
  lmts_pkg::mode_t                 mode;
  logic [lmts_pkg::DOTS_W-1:0]     dots_remaining;
  logic [7:0]                      line;
  logic                            status_prev;

  lmts_pkg::mode_t                 mode_next;
  logic [lmts_pkg::DOTS_W-1:0]     dots_remaining_next;
  logic [7:0]                      line_next;
  logic                            status_prev_next;

  logic                            s_accept;
  logic [lmts_pkg::DOTS_W-1:0]     dots;
  logic [lmts_pkg::DOTS_W-1:0]     spill;
  logic                            budget_done;
  logic [7:0]                      line_inc;
  logic [3:0]                      vb_line_ofs;
  logic                            coinc;
  logic                            status_now;
  logic                            vblank_irq;
  logic                            status_irq;
  logic [1:0]                      lcd_mode;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // config writes, index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable     <= 1'b0;
      line_compare       <= 8'd0;
      status_irq_enables <= 4'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lmts_pkg::REG_DISPLAY_ENABLE:     display_enable     <= cfg_data[0];
        lmts_pkg::REG_LINE_COMPARE:       line_compare       <= cfg_data;
        lmts_pkg::REG_STATUS_IRQ_ENABLES: status_irq_enables <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign dots        = {{(lmts_pkg::DOTS_W-5){1'b0}}, s_tdata[4:0]};
  // budgets are never below 80 dots so at most one mode change per transaction
  assign budget_done = dots >= dots_remaining;
  assign spill       = dots - dots_remaining;
  assign line_inc    = line + 8'd1;

  // mode sequencing
  always_comb begin
    mode_next           = mode;
    dots_remaining_next = dots_remaining;
    line_next           = line;
    vblank_irq          = 1'b0;
    if (!display_enable) begin
      mode_next           = lmts_pkg::ST_OFF;
      dots_remaining_next = '0;
      line_next           = 8'd0;
    end else begin
      unique case (mode)
        lmts_pkg::ST_SEARCH: begin
          if (budget_done) begin
            mode_next           = lmts_pkg::ST_XFER;
            dots_remaining_next = lmts_pkg::DOTS_XFER - spill;
          end else begin
            dots_remaining_next = dots_remaining - dots;
          end
        end
        lmts_pkg::ST_XFER: begin
          if (budget_done) begin
            mode_next           = lmts_pkg::ST_HBLANK;
            dots_remaining_next = lmts_pkg::DOTS_HBLANK - spill;
          end else begin
            dots_remaining_next = dots_remaining - dots;
          end
        end
        lmts_pkg::ST_HBLANK: begin
          if (budget_done) begin
            line_next = line_inc;
            if (line_inc == lmts_pkg::VISIBLE_LINES) begin
              mode_next           = lmts_pkg::ST_VBLANK;
              dots_remaining_next = lmts_pkg::DOTS_VBLANK - spill;
              vblank_irq          = 1'b1;
            end else begin
              mode_next           = lmts_pkg::ST_SEARCH;
              dots_remaining_next = lmts_pkg::DOTS_SEARCH - spill;
            end
          end else begin
            dots_remaining_next = dots_remaining - dots;
          end
        end
        lmts_pkg::ST_VBLANK: begin
          if (budget_done) begin
            mode_next           = lmts_pkg::ST_SEARCH;
            line_next           = 8'd0;
            dots_remaining_next = lmts_pkg::DOTS_SEARCH - spill;
          end else begin
            dots_remaining_next = dots_remaining - dots;
          end
        end
        default: begin
          // leaving the off state: object search on line 0, then spend dots
          mode_next           = lmts_pkg::ST_SEARCH;
          line_next           = 8'd0;
          dots_remaining_next = lmts_pkg::DOTS_SEARCH - dots;
        end
      endcase
      // in vertical blank the line follows the dots spent so far
      if (mode_next == lmts_pkg::ST_VBLANK) begin
        line_next = lmts_pkg::VISIBLE_LINES + {4'd0, vb_line_ofs};
      end
    end
  end

  // whole lines elapsed in vertical blank, one threshold compare per line
  always_comb begin
    vb_line_ofs = 4'd0;
    for (int k = 1; k < lmts_pkg::VBLANK_LINES; k++) begin
      if (dots_remaining_next <=
          lmts_pkg::DOTS_W'(lmts_pkg::DOTS_VBLANK - lmts_pkg::DOTS_LINE * k)) begin
        vb_line_ofs = vb_line_ofs + 4'd1;
      end
    end
  end

  // status line and its rising edge
  assign coinc = line_next == line_compare;

  always_comb begin
    status_now = 1'b0;
    if (mode_next == lmts_pkg::ST_HBLANK && status_irq_enables[0]) status_now = 1'b1;
    if (mode_next == lmts_pkg::ST_VBLANK && status_irq_enables[1]) status_now = 1'b1;
    if (mode_next == lmts_pkg::ST_SEARCH && status_irq_enables[2]) status_now = 1'b1;
    if (coinc && status_irq_enables[3]) status_now = 1'b1;
  end

  assign status_prev_next = display_enable && status_now;
  assign status_irq       = display_enable && status_now && !status_prev;

  // lcd_mode code of the new state, off reads as horizontal blank
  always_comb begin
    unique case (mode_next)
      lmts_pkg::ST_VBLANK: lcd_mode = lmts_pkg::LCD_VBLANK;
      lmts_pkg::ST_SEARCH: lcd_mode = lmts_pkg::LCD_SEARCH;
      lmts_pkg::ST_XFER:   lcd_mode = lmts_pkg::LCD_XFER;
      default:             lcd_mode = lmts_pkg::LCD_HBLANK;
    endcase
  end

  // state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lmts_pkg::ST_OFF;
      dots_remaining <= '0;
      line           <= 8'd0;
      status_prev    <= 1'b0;
    end else if (s_accept) begin
      mode           <= mode_next;
      dots_remaining <= dots_remaining_next;
      line           <= line_next;
      status_prev    <= status_prev_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {3'd0, status_irq, vblank_irq, coinc, line_next, lcd_mode};
    end
  end

endmodule

[rtl/lmts_checker.sv]
// ----------------------------------------------------------------------------
// lmts_checker
// Port-level checks for the LCD mode timing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lmts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic [1:0] r_mode;
  logic [7:0] r_line;
  logic       r_vblank_irq;

  assign r_mode       = m_tdata[lmts_pkg::OUT_MODE_LSB +: 2];
  assign r_line       = m_tdata[lmts_pkg::OUT_LINE_LSB +: 8];
  assign r_vblank_irq = m_tdata[lmts_pkg::OUT_VBLANK];

  // vblank interrupt only on entry to vertical blank at the first blank line
  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r_vblank_irq |->
      r_mode == lmts_pkg::LCD_VBLANK && r_line == lmts_pkg::VISIBLE_LINES)
    else $error("vblank_irq outside vertical blank entry");

  // vertical blank lines sit after the visible area, below line 154
  a_vblank_lines: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r_mode == lmts_pkg::LCD_VBLANK |->
      r_line >= lmts_pkg::VISIBLE_LINES &&
      r_line < lmts_pkg::VISIBLE_LINES + 8'(lmts_pkg::VBLANK_LINES))
    else $error("vertical blank on a visible line");

  // object search and pixel transfer happen on visible lines only
  a_active_lines: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r_mode == lmts_pkg::LCD_SEARCH || r_mode == lmts_pkg::LCD_XFER) |->
      r_line < lmts_pkg::VISIBLE_LINES)
    else $error("active mode outside visible lines");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind lcd_mode_timing_sequencer_top lmts_checker u_lmts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[sim/lcd_mode_timing_sequencer_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_top_test
// Self-checking bench for the LCD mode sequencer. A short stimulus table walks
// reset, display on/off, exact mode budgets and status edges caused by
// register writes. Random phases with large dot counts then run down a few
// dozen scan lines. Every result is compared field by field with a
// cycle-free model of the mode, line and interrupt logic.
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer_top_test;

  // random part: 8 phases of 108 transactions, about 22 dots each, so the
  // display-on phases run down a few dozen lines of the frame
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 108;
  localparam int OFF_PHASE       = 1;    // display held off for this phase
  localparam int HOLD_PHASE      = 3;    // receiver holds off here
  localparam int LONG_HOLD       = 150;  // receiver hold-off length, in cycles
  // slowest run: ~900 transactions, each with the longest idle and stall gaps
  localparam int CYCLE_LIMIT     = 1_000_000;

  // result fields, msb first; lines up with m_tdata[12:0]
  typedef struct packed {
    logic       st_irq;
    logic       vb_irq;
    logic       coinc;
    logic [7:0] line;
    logic [1:0] mode;
  } lcd_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  // one row of the directed table: a transaction or a register write
  typedef struct packed {
    row_op_t     op;
    logic [1:0]  index;
    logic [7:0]  value;
    logic        typed;   // want holds a hand-written expectation
    lcd_result_t want;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data  = 8'd0;

  lcd_mode_timing_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the config registers
  logic             shadow_display_on;
  logic [7:0]       shadow_line_cmp;
  logic [3:0]       shadow_irq_en;

  // sequencer state as the bench sees it
  lmts_pkg::mode_t             lcd_state;
  logic [lmts_pkg::DOTS_W-1:0] dots_left;
  logic [7:0]       scan_line;
  logic             stat_line_prev;

  lcd_result_t      expected_results[$];
  stim_row_t        directed_rows[$];
  int               mismatches    = 0;
  int               cycle_count   = 0;
  bit               idle_on       = 1'b1;
  bit               hold_results  = 1'b0;

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // samples the OR of enabled status sources, reports a rising edge
  function automatic logic status_line_rose();
    logic s;
    s = (lcd_state == lmts_pkg::ST_HBLANK && shadow_irq_en[0]) ||
        (lcd_state == lmts_pkg::ST_VBLANK && shadow_irq_en[1]) ||
        (lcd_state == lmts_pkg::ST_SEARCH && shadow_irq_en[2]) ||
        (scan_line == shadow_line_cmp && shadow_irq_en[3]);
    status_line_rose = s && !stat_line_prev;
    stat_line_prev   = s;
  endfunction

  // spends one transaction's dots and returns the result it must produce
  function automatic lcd_result_t advance_lcd_timing(input logic [4:0] elapsed);
    int unsigned dots;
    logic        vb;
    logic        st;
    lcd_result_t r;
    dots = {27'd0, elapsed};
    vb   = 1'b0;
    st   = 1'b0;
    if (!shadow_display_on) begin
      lcd_state      = lmts_pkg::ST_OFF;
      scan_line      = 8'd0;
      dots_left      = '0;
      stat_line_prev = 1'b0;
    end else begin
      // display just came on: start object search on line 0
      if (lcd_state == lmts_pkg::ST_OFF) begin
        lcd_state = lmts_pkg::ST_SEARCH;
        scan_line = 8'd0;
        dots_left = lmts_pkg::DOTS_SEARCH;
        st |= status_line_rose();
      end
      while (dots != 0) begin
        if (dots < dots_left) begin
          dots_left = dots_left - lmts_pkg::DOTS_W'(dots);
          dots      = 0;
        end else begin
          // budget used up, leftover dots spill into the next mode
          dots = dots - dots_left;
          case (lcd_state)
            lmts_pkg::ST_SEARCH: begin
              lcd_state = lmts_pkg::ST_XFER;
              dots_left = lmts_pkg::DOTS_XFER;
            end
            lmts_pkg::ST_XFER: begin
              lcd_state = lmts_pkg::ST_HBLANK;
              dots_left = lmts_pkg::DOTS_HBLANK;
            end
            lmts_pkg::ST_HBLANK: begin
              scan_line = scan_line + 8'd1;
              if (scan_line == lmts_pkg::VISIBLE_LINES) begin
                lcd_state = lmts_pkg::ST_VBLANK;
                dots_left = lmts_pkg::DOTS_VBLANK;
                vb        = 1'b1;
              end else begin
                lcd_state = lmts_pkg::ST_SEARCH;
                dots_left = lmts_pkg::DOTS_SEARCH;
              end
            end
            default: begin
              // end of vertical blank, new frame
              lcd_state = lmts_pkg::ST_SEARCH;
              scan_line = 8'd0;
              dots_left = lmts_pkg::DOTS_SEARCH;
            end
          endcase
          st |= status_line_rose();
        end
      end
      // vertical blank line follows the dots spent in it, 456 per line
      if (lcd_state == lmts_pkg::ST_VBLANK)
        scan_line = 8'(lmts_pkg::VISIBLE_LINES +
                       (lmts_pkg::DOTS_VBLANK - dots_left) / lmts_pkg::DOTS_LINE);
      st |= status_line_rose();
    end
    case (lcd_state)
      lmts_pkg::ST_HBLANK: r.mode = lmts_pkg::LCD_HBLANK;
      lmts_pkg::ST_VBLANK: r.mode = lmts_pkg::LCD_VBLANK;
      lmts_pkg::ST_SEARCH: r.mode = lmts_pkg::LCD_SEARCH;
      lmts_pkg::ST_XFER:   r.mode = lmts_pkg::LCD_XFER;
      default:             r.mode = lmts_pkg::LCD_HBLANK;   // off state reads as hblank
    endcase
    r.line   = scan_line;
    r.coinc  = (scan_line == shadow_line_cmp);
    r.vb_irq = vb;
    r.st_irq = st;
    advance_lcd_timing = r;
  endfunction

  // ---------------------------------------------------------------------------
  // random choices
  // ---------------------------------------------------------------------------

  // idle length for either side: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) pick_gap = 0;
    else if (r < 90)        pick_gap = $urandom_range(1, 3);
    else                    pick_gap = $urandom_range(8, 30);
  endfunction

  // mostly large counts so many lines go by, plus small counts and the extremes
  function automatic logic [4:0] pick_dots();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)      pick_dots = 5'($urandom_range(20, 31));
    else if (r < 90) pick_dots = 5'($urandom_range(1, 19));
    else begin
      case ($urandom_range(0, 3))
        0:       pick_dots = 5'd0;
        1:       pick_dots = 5'd31;
        2:       pick_dots = 5'd1;
        default: pick_dots = 5'd24;
      endcase
    end
  endfunction

  // compare values biased to extremes and the vertical blank lines
  function automatic logic [7:0] pick_line_compare();
    case ($urandom_range(0, 5))
      0:       pick_line_compare = 8'd0;
      1:       pick_line_compare = 8'd255;
      2:       pick_line_compare = 8'(lmts_pkg::VISIBLE_LINES + $urandom_range(0, 9));
      3:       pick_line_compare = lmts_pkg::VISIBLE_LINES;
      4:       pick_line_compare = 8'($urandom_range(0, 143));
      default: pick_line_compare = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  function automatic void add_row(input row_op_t op, input logic [1:0] index,
                                  input logic [7:0] value, input logic typed,
                                  input lcd_result_t want);
    stim_row_t row;
    row.op    = op;
    row.index = index;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // offers one transaction, predicts its result once it is taken
  task automatic send_item(input logic [4:0] dots, input logic typed,
                           input lcd_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, dots};
    do @(posedge clk); while (s_tready !== 1'b1);
    if (typed) begin
      void'(advance_lcd_timing(dots));
      expected_results.push_back(want);
    end else begin
      expected_results.push_back(advance_lcd_timing(dots));
    end
  endtask

  // sender stops and waits until every result is back, plus the latency
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register write; caller drops cfg_write after the last one
  task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      lmts_pkg::REG_DISPLAY_ENABLE:     shadow_display_on = value[0];
      lmts_pkg::REG_LINE_COMPARE:       shadow_line_cmp   = value;
      lmts_pkg::REG_STATUS_IRQ_ENABLES: shadow_irq_en     = value[3:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic check_result(input logic [15:0] word);
    lcd_result_t got;
    lcd_result_t want;
    got.mode   = word[lmts_pkg::OUT_MODE_LSB +: 2];
    got.line   = word[lmts_pkg::OUT_LINE_LSB +: 8];
    got.coinc  = word[lmts_pkg::OUT_COINC];
    got.vb_irq = word[lmts_pkg::OUT_VBLANK];
    got.st_irq = word[lmts_pkg::OUT_STATUS];
    if (expected_results.size() == 0) begin
      $error("result %h arrived with nothing pending", word);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.mode !== want.mode) begin
        $error("lcd_mode expected %0d actual %0d", want.mode, got.mode);
        mismatches++;
      end
      if (got.line !== want.line) begin
        $error("current_line expected %0d actual %0d", want.line, got.line);
        mismatches++;
      end
      if (got.coinc !== want.coinc) begin
        $error("coincidence expected %0d actual %0d", want.coinc, got.coinc);
        mismatches++;
      end
      if (got.vb_irq !== want.vb_irq) begin
        $error("vblank_irq expected %0d actual %0d", want.vb_irq, got.vb_irq);
        mismatches++;
      end
      if (got.st_irq !== want.st_irq) begin
        $error("status_irq expected %0d actual %0d", want.st_irq, got.st_irq);
        mismatches++;
      end
    end
  endtask

  // receiver: takes results with random stalls, long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) check_result(m_tdata);
      if (hold_results) begin
        hold_results = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin : cycle_watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int n;
    int phase;

    // reset state of the shadow registers and the sequencer
    shadow_display_on = 1'b0;
    shadow_line_cmp   = 8'd0;
    shadow_irq_en     = 4'd0;
    lcd_state         = lmts_pkg::ST_OFF;
    dots_left         = '0;
    scan_line         = 8'd0;
    stat_line_prev    = 1'b0;

    // directed table; typed rows give {st, vb, coinc, line, mode}
    // display off after reset: line 0, compares equal to the reset compare
    add_row(ROW_ITEM, '0, 8'd0,  1'b1, {1'b0, 1'b0, 1'b1, 8'd0, lmts_pkg::LCD_HBLANK});
    add_row(ROW_ITEM, '0, 8'd31, 1'b1, {1'b0, 1'b0, 1'b1, 8'd0, lmts_pkg::LCD_HBLANK});
    add_row(ROW_CFG, lmts_pkg::REG_LINE_COMPARE, 8'd255, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd5,  1'b1, {1'b0, 1'b0, 1'b0, 8'd0, lmts_pkg::LCD_HBLANK});
    // switch on with zero dots: object search, search source rises
    add_row(ROW_CFG, lmts_pkg::REG_STATUS_IRQ_ENABLES, 8'h04, 1'b0, '0);
    add_row(ROW_CFG, lmts_pkg::REG_DISPLAY_ENABLE, 8'd1, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd0,  1'b1, {1'b1, 1'b0, 1'b0, 8'd0, lmts_pkg::LCD_SEARCH});
    // object search ends exactly on its budget
    add_row(ROW_ITEM, '0, 8'd31, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd31, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd17, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd1,  1'b0, '0);
    // pixel transfer, then hblank, each ending exactly on budget
    for (i = 0; i < 5; i++) add_row(ROW_ITEM, '0, 8'd31, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd17, 1'b0, '0);
    for (i = 0; i < 6; i++) add_row(ROW_ITEM, '0, 8'd31, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd18, 1'b0, '0);
    // status edge caused by a register change alone, with zero dots
    add_row(ROW_CFG, lmts_pkg::REG_STATUS_IRQ_ENABLES, 8'h00, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd0,  1'b0, '0);
    add_row(ROW_CFG, lmts_pkg::REG_LINE_COMPARE, 8'd1, 1'b0, '0);
    add_row(ROW_CFG, lmts_pkg::REG_STATUS_IRQ_ENABLES, 8'h08, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd0,  1'b0, '0);
    // display off again: everything quiet, line 0 no longer matches
    add_row(ROW_CFG, lmts_pkg::REG_STATUS_IRQ_ENABLES, 8'h0f, 1'b0, '0);
    add_row(ROW_CFG, lmts_pkg::REG_DISPLAY_ENABLE, 8'd0, 1'b0, '0);
    add_row(ROW_ITEM, '0, 8'd31, 1'b1, {1'b0, 1'b0, 1'b0, 8'd0, lmts_pkg::LCD_HBLANK});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].index, directed_rows[i].value);
        cfg_write <= 1'b0;
      end else begin
        send_item(directed_rows[i].value[4:0], directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    // random phases: display stays on across most of them so the frame
    // keeps running line after line
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      // some phases run with no idling on either side
      idle_on = (phase % 3 != 2) && (phase != HOLD_PHASE);
      write_reg(lmts_pkg::REG_DISPLAY_ENABLE, (phase == OFF_PHASE) ? 8'd0 : 8'd1);
      write_reg(lmts_pkg::REG_LINE_COMPARE, pick_line_compare());
      write_reg(lmts_pkg::REG_STATUS_IRQ_ENABLES, 8'($urandom_range(0, 15)));
      cfg_write <= 1'b0;
      // receiver holds off while the sender keeps offering back to back
      if (phase == HOLD_PHASE) hold_results = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_item(pick_dots(), 1'b0, '0);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
